[design/ftach_pkg.sv]
package ftach_pkg;

    localparam int NUM_BITS     = 32;
    localparam int CNT_BITS     = $clog2(NUM_BITS);
    localparam int IDLE_BITS    = 16;
    localparam int FAN_BITS     = 3;
    localparam int CAPTURE_BITS = 16;
    localparam int SPEED_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [IDLE_BITS-1:0] IDLE_MAX         = 16'hFFFF;
    localparam logic [NUM_BITS-1:0]  RPM_NUM_RESET    = 32'd22500000;
    localparam logic [IDLE_BITS-1:0] IDLE_LIMIT_RESET = 16'd50000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RPM_NUMERATOR   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_POLL_LIMIT = 1'b1;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_FINISH
    } ftach_state_t;

    typedef struct packed {
        logic take;
        logic update;
        logic step;
        logic load_out;
    } ftach_cmd_t;

    typedef struct packed {
        logic is_poll;
        logic need_div;
        logic div_last;
        logic out_busy;
    } ftach_status_t;

endpackage

[design/ftach_tach_if.sv]
interface ftach_tach_if import ftach_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [FAN_BITS-1:0]     fan_index;
    logic [CAPTURE_BITS-1:0] capture_value;

    modport source (output valid, output op, output fan_index, output capture_value,
                    input ready);
    modport sink (input valid, input op, input fan_index, input capture_value,
                  output ready);
endinterface

[design/ftach_speed_if.sv]
interface ftach_speed_if import ftach_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FAN_BITS-1:0]   out_fan;
    logic [SPEED_BITS-1:0] speed_rpm;

    modport source (output valid, output out_fan, output speed_rpm, input ready);
    modport sink (input valid, input out_fan, input speed_rpm, output ready);
endinterface

[design/fan_tach_rpm_meter_unit.sv]
// channel | dir | fields                        | accepted when
// tach    | in  | op, fan_index, capture_value  | tach.valid && tach.ready
// speed   | out | out_fan, speed_rpm            | speed.valid && speed.ready
// cfg     | in  | cfg_index, cfg_data           | cfg_we
//
// Capture word: accept, then state update; no result.
// Poll word: accept, state update, division when one is needed, then the result load; the restoring
//   divider takes one quotient bit per cycle over the 32 numerator bits.
// Reset clears all fan state and loads the register defaults.
// A finished result waits in the output register while the next word is taken;
//   a later poll holds in its final cycle until that register frees up.
module fan_tach_rpm_meter_unit import ftach_pkg::*;
#(
    parameter int FAN_COUNT  = 5,
    parameter int STAMP_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    ftach_tach_if.sink              tach,
    ftach_speed_if.source           speed,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [NUM_BITS-1:0]     cfg_data
);

    ftach_cmd_t    cmd;
    ftach_status_t status;
    logic          tach_ready;
    logic          speed_valid;
    logic [FAN_BITS-1:0]   speed_fan;
    logic [SPEED_BITS-1:0] speed_rpm;

    assign tach.ready      = tach_ready;
    assign speed.valid     = speed_valid;
    assign speed.out_fan   = speed_fan;
    assign speed.speed_rpm = speed_rpm;

    ftach_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tach_valid (tach.valid),
        .tach_ready (tach_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ftach_dp #(
        .FAN_COUNT  (FAN_COUNT),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tach_op      (tach.op),
        .tach_fan     (tach.fan_index),
        .tach_capture (tach.capture_value),
        .speed_valid  (speed_valid),
        .speed_ready  (speed.ready),
        .speed_fan    (speed_fan),
        .speed_rpm    (speed_rpm),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[design/ftach_ctrl.sv]
module ftach_ctrl import ftach_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tach_valid,
    output logic          tach_ready,
    input  ftach_status_t status,
    output ftach_cmd_t    cmd
);

    ftach_state_t state_reg;
    ftach_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tach_ready   = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                tach_ready = 1'b1;
                cmd.take   = tach_valid;
                if (tach_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!status.is_poll)
                begin
                    state_next = S_IDLE;
                end
                else if (status.need_div)
                begin
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (tach_valid && tach_ready) |=> (state_reg == S_UPDATE))
        else $error("accepted word did not start an update");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && status.div_last) |=> (state_reg == S_FINISH))
        else $error("divider finished but result not pending");

    a_capture_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && !status.is_poll) |=> (state_reg == S_IDLE))
        else $error("capture word went on past update");
`endif

endmodule

[design/ftach_dp.sv]
module ftach_dp import ftach_pkg::*;
#(
    parameter int FAN_COUNT  = 5,
    parameter int STAMP_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [NUM_BITS-1:0]     cfg_data,
    input  logic                    tach_op,
    input  logic [FAN_BITS-1:0]     tach_fan,
    input  logic [CAPTURE_BITS-1:0] tach_capture,
    output logic                    speed_valid,
    input  logic                    speed_ready,
    output logic [FAN_BITS-1:0]     speed_fan,
    output logic [SPEED_BITS-1:0]   speed_rpm,
    input  ftach_cmd_t              cmd,
    output ftach_status_t           status
);

    localparam int FI_BITS = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

    logic [NUM_BITS-1:0]   num_reg;
    logic [IDLE_BITS-1:0]  limit_reg;

    logic                  item_op_reg;
    logic [FAN_BITS-1:0]   item_fan_reg;
    logic [STAMP_BITS-1:0] item_stamp_reg;

    logic [STAMP_BITS-1:0] last_reg [FAN_COUNT];
    logic [STAMP_BITS-1:0] avg_reg  [FAN_COUNT];
    logic [IDLE_BITS-1:0]  idle_reg [FAN_COUNT];
    logic [FAN_COUNT-1:0]  seen_reg;

    logic [STAMP_BITS-1:0] divisor_reg;
    logic [STAMP_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0]   qd_reg;
    logic [CNT_BITS-1:0]   cnt_reg;

    logic                  speed_valid_reg;
    logic [FAN_BITS-1:0]   speed_fan_reg;
    logic [SPEED_BITS-1:0] speed_rpm_reg;

    logic                  fan_valid;
    logic [FI_BITS-1:0]    fan_sel;
    logic [STAMP_BITS-1:0] cur_last;
    logic [STAMP_BITS-1:0] cur_avg;
    logic [IDLE_BITS-1:0]  cur_idle;
    logic                  cur_seen;
    logic [STAMP_BITS-1:0] diff;
    logic [STAMP_BITS:0]   sum;
    logic [STAMP_BITS-1:0] cap_avg;
    logic [IDLE_BITS-1:0]  idle_inc;
    logic [STAMP_BITS-1:0] poll_avg;
    logic                  need_div;
    logic [STAMP_BITS:0]   shifted;
    logic [STAMP_BITS:0]   trial;
    logic                  ge;

    assign fan_valid = (32'(item_fan_reg) < FAN_COUNT);
    assign fan_sel   = fan_valid ? FI_BITS'(item_fan_reg) : '0;
    assign cur_last  = last_reg[fan_sel];
    assign cur_avg   = avg_reg[fan_sel];
    assign cur_idle  = idle_reg[fan_sel];
    assign cur_seen  = seen_reg[fan_sel];

    // capture: average the wrapped period with the old one
    assign diff    = item_stamp_reg - cur_last;
    assign sum     = {1'b0, cur_avg} + {1'b0, diff};
    assign cap_avg = sum[STAMP_BITS:1];

    // poll: age the idle count, drop the period on timeout
    assign idle_inc = (!cur_seen && cur_idle != IDLE_MAX) ? cur_idle + 1'b1 : cur_idle;
    assign poll_avg = (idle_inc > limit_reg) ? '0 : cur_avg;
    assign need_div = (item_op_reg == OP_POLL) && fan_valid && (poll_avg != '0);

    // one restoring step per cycle
    assign shifted = {rem_reg, qd_reg[NUM_BITS-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign ge      = (shifted >= {1'b0, divisor_reg});

    assign status.is_poll  = (item_op_reg == OP_POLL);
    assign status.need_div = need_div;
    assign status.div_last = (cnt_reg == '0);
    assign status.out_busy = speed_valid_reg && !speed_ready;

    assign speed_valid = speed_valid_reg;
    assign speed_fan   = speed_fan_reg;
    assign speed_rpm   = speed_rpm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= RPM_NUM_RESET;
            limit_reg <= IDLE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RPM_NUMERATOR:   num_reg   <= cfg_data;
                CFG_IDLE_POLL_LIMIT: limit_reg <= cfg_data[IDLE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FAN_COUNT; i++)
            begin
                last_reg[i] <= '0;
                avg_reg[i]  <= '0;
                idle_reg[i] <= '0;
            end
            seen_reg <= '0;
        end
        else if (cmd.update && fan_valid)
        begin
            if (item_op_reg == OP_CAPTURE)
            begin
                last_reg[fan_sel] <= item_stamp_reg;
                avg_reg[fan_sel]  <= cap_avg;
                idle_reg[fan_sel] <= '0;
                seen_reg[fan_sel] <= 1'b1;
            end
            else
            begin
                avg_reg[fan_sel]  <= poll_avg;
                idle_reg[fan_sel] <= idle_inc;
                seen_reg[fan_sel] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_op_reg    <= tach_op;
            item_fan_reg   <= tach_fan;
            item_stamp_reg <= STAMP_BITS'(tach_capture);
        end
        if (cmd.update)
        begin
            divisor_reg <= poll_avg;
            rem_reg     <= '0;
            qd_reg      <= need_div ? num_reg : '0;
            cnt_reg     <= '1;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? trial[STAMP_BITS-1:0] : shifted[STAMP_BITS-1:0];
            qd_reg  <= {qd_reg[NUM_BITS-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.load_out)
        begin
            speed_fan_reg <= item_fan_reg;
            speed_rpm_reg <= qd_reg[SPEED_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            speed_valid_reg <= 1'b1;
        end
        else if (speed_ready)
        begin
            speed_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg < divisor_reg))
        else $error("divider remainder out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(speed_valid_reg && !speed_ready))
        else $error("result overwrote a waiting word");

    a_capture_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && fan_valid && item_op_reg == OP_CAPTURE)
        |=> (idle_reg[$past(fan_sel)] == '0 && seen_reg[$past(fan_sel)]))
        else $error("capture did not reset idle state");
`endif

endmodule

[tb/sv/testbench.sv]
module testbench;
    import ftach_pkg::*;

    localparam int  FANS       = 5;
    localparam int  RUN_LIMIT  = 1500000;
    localparam int  SETTLE     = 60;

    typedef struct packed {
        logic [FAN_BITS-1:0]   fan;
        logic [SPEED_BITS-1:0] rpm;
    } speed_word_t;

    // per-fan speed prediction plus the queue of speed words still owed
    class rpm_checker;
        logic [NUM_BITS-1:0]     rpm_num;
        logic [IDLE_BITS-1:0]    idle_limit;
        logic [CAPTURE_BITS-1:0] fan_stamp  [FANS];
        logic [CAPTURE_BITS-1:0] fan_period [FANS];
        logic [IDLE_BITS-1:0]    fan_idle   [FANS];
        logic                    fan_fresh  [FANS];
        speed_word_t             expected_speeds [$];
        int                      errors;

        function new();
            rpm_num    = RPM_NUM_RESET;
            idle_limit = IDLE_LIMIT_RESET;
            errors     = 0;
            for (int f = 0; f < FANS; f++)
            begin
                fan_stamp[f]  = '0;
                fan_period[f] = '0;
                fan_idle[f]   = '0;
                fan_fresh[f]  = 1'b0;
            end
        endfunction

        function void note_word(logic op, logic [FAN_BITS-1:0] fan,
                                logic [CAPTURE_BITS-1:0] stamp);
            logic [CAPTURE_BITS-1:0] diff;
            logic [CAPTURE_BITS:0]   sum;
            logic [NUM_BITS-1:0]     quot;
            speed_word_t             w;
            if (op == OP_CAPTURE)
            begin
                // captures on a nonexistent fan are dropped
                if (int'(fan) < FANS)
                begin
                    diff = stamp - fan_stamp[fan];
                    sum  = {1'b0, fan_period[fan]} + {1'b0, diff};
                    fan_period[fan] = sum[CAPTURE_BITS:1];
                    fan_stamp[fan]  = stamp;
                    fan_fresh[fan]  = 1'b1;
                    fan_idle[fan]   = '0;
                end
            end
            else
            begin
                w.fan = fan;
                w.rpm = '0;
                if (int'(fan) < FANS)
                begin
                    if (!fan_fresh[fan] && fan_idle[fan] != IDLE_MAX)
                        fan_idle[fan] = fan_idle[fan] + 1'b1;
                    fan_fresh[fan] = 1'b0;
                    if (fan_idle[fan] > idle_limit)
                        fan_period[fan] = '0;
                    if (fan_period[fan] != '0)
                    begin
                        quot  = rpm_num / {16'b0, fan_period[fan]};
                        w.rpm = quot[SPEED_BITS-1:0];
                    end
                end
                expected_speeds.push_back(w);
            end
        endfunction

        function void check_speed(logic [FAN_BITS-1:0] fan, logic [SPEED_BITS-1:0] rpm);
            speed_word_t w;
            if (expected_speeds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected speed word: fan %0d rpm %0d", fan, rpm);
            end
            else
            begin
                w = expected_speeds.pop_front();
                if (w.fan !== fan)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("out_fan mismatch: expected %0d, got %0d", w.fan, fan);
                end
                if (w.rpm !== rpm)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("speed_rpm mismatch on fan %0d: expected %0d, got %0d",
                                 w.fan, w.rpm, rpm);
                end
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [NUM_BITS-1:0]     cfg_data;

    ftach_tach_if  tach_ch ();
    ftach_speed_if speed_ch ();

    fan_tach_rpm_meter_unit #(
        .FAN_COUNT  (FANS),
        .STAMP_BITS (16)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tach      (tach_ch),
        .speed     (speed_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rpm_checker              sb;
    int                      send_idle_pct;
    int                      stall_pct;
    int                      cycle_count = 0;
    logic [CAPTURE_BITS-1:0] stamp_track [FANS];
    int                      base_gap    [FANS];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        speed_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tach_ch.valid && tach_ch.ready)
                sb.note_word(tach_ch.op, tach_ch.fan_index, tach_ch.capture_value);
            if (speed_ch.valid && speed_ch.ready)
                sb.check_speed(speed_ch.out_fan, speed_ch.speed_rpm);
        end
    end

    task send_word(input logic op, input logic [FAN_BITS-1:0] fan,
                   input logic [CAPTURE_BITS-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tach_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tach_ch.valid         <= 1'b1;
        tach_ch.op            <= op;
        tach_ch.fan_index     <= fan;
        tach_ch.capture_value <= stamp;
        @(posedge clk);
        while (!tach_ch.ready)
            @(posedge clk);
    endtask

    // a capture leaves no word behind, so give the unit time to finish it too
    task drain;
        tach_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_config(input logic [NUM_BITS-1:0] numerator, input logic [IDLE_BITS-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RPM_NUMERATOR;
        cfg_data  <= numerator;
        @(posedge clk);
        // upper data bits are don't-care for the 16-bit limit
        cfg_index <= CFG_IDLE_POLL_LIMIT;
        cfg_data  <= {16'($urandom), limit};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.rpm_num    = numerator;
        sb.idle_limit = limit;
        @(posedge clk);
    endtask

    task run_random(input int count, input int idle_pct, input int stall);
        int                      fan;
        int                      gap;
        logic [CAPTURE_BITS-1:0] stamp;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            fan = $urandom_range(0, FANS - 1);
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       base_gap[fan] = $urandom_range(1, 8);
                    1:       base_gap[fan] = $urandom_range(100, 5000);
                    default: base_gap[fan] = $urandom_range(20000, 65535);
                endcase
            end
            if ($urandom_range(0, 99) < 80)
            begin
                // regular tach traffic: steady period with jitter, mixed with polls
                if ($urandom_range(0, 9) < 6)
                begin
                    gap   = base_gap[fan] + $urandom_range(0, base_gap[fan] / 8);
                    stamp = stamp_track[fan] + 16'(gap);
                    stamp_track[fan] = stamp;
                    send_word(OP_CAPTURE, 3'(fan), stamp);
                end
                else
                    send_word(OP_POLL, 3'(fan), 16'($urandom));
            end
            else
                send_word(1'($urandom), 3'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int f = 0; f < FANS; f++)
        begin
            stamp_track[f] = 16'($urandom);
            base_gap[f]    = $urandom_range(100, 5000);
        end
        rst_n                  = 1'b0;
        tach_ch.valid         <= 1'b0;
        tach_ch.op            <= OP_CAPTURE;
        tach_ch.fan_index     <= '0;
        tach_ch.capture_value <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_RPM_NUMERATOR;
        cfg_data              <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register defaults
        send_word(OP_POLL,    3'd0, 16'h0000);     // nothing captured yet
        send_word(OP_CAPTURE, 3'd0, 16'd1000);
        send_word(OP_CAPTURE, 3'd0, 16'd1200);
        send_word(OP_POLL,    3'd0, 16'hFFFF);
        send_word(OP_CAPTURE, 3'd1, 16'hFFFF);
        send_word(OP_CAPTURE, 3'd1, 16'h0000);     // timer wraps
        send_word(OP_CAPTURE, 3'd1, 16'h0010);
        send_word(OP_POLL,    3'd1, 16'h0000);
        send_word(OP_CAPTURE, 3'd5, 16'h1234);     // nonexistent fans
        send_word(OP_CAPTURE, 3'd7, 16'hFFFF);
        send_word(OP_POLL,    3'd5, 16'h0000);
        send_word(OP_POLL,    3'd6, 16'h0000);
        send_word(OP_POLL,    3'd7, 16'hFFFF);
        send_word(OP_POLL,    3'd4, 16'h0000);
        drain();

        // widest numerator, instant timeout, quotient overflows 16 bits
        write_config(32'hFFFF_FFFF, 16'd0);
        send_word(OP_CAPTURE, 3'd3, 16'd2);
        send_word(OP_POLL,    3'd3, 16'd0);
        send_word(OP_POLL,    3'd3, 16'd0);
        send_word(OP_CAPTURE, 3'd2, 16'h8000);
        send_word(OP_POLL,    3'd2, 16'd0);
        drain();

        // smallest numerator, timeout disabled
        write_config(32'd1, 16'hFFFF);
        send_word(OP_CAPTURE, 3'd3, 16'd3);
        send_word(OP_CAPTURE, 3'd3, 16'd5);
        send_word(OP_POLL,    3'd3, 16'd0);
        send_word(OP_POLL,    3'd3, 16'd0);
        send_word(OP_POLL,    3'd3, 16'd0);
        send_word(OP_POLL,    3'd3, 16'd0);
        drain();

        write_config(RPM_NUM_RESET, 16'd3);
        run_random(400, 0, 0);
        write_config(32'($urandom), 16'($urandom_range(0, 6)));
        run_random(400, 82, 0);
        write_config(32'hFFFF_FFFF, 16'd2);
        run_random(400, 0, 82);
        write_config(32'($urandom_range(1000, 100000000)), 16'd0);
        run_random(400, 20, 20);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/ftach_pkg.sv
design/ftach_tach_if.sv
design/ftach_speed_if.sv
design/ftach_ctrl.sv
design/ftach_dp.sv
design/fan_tach_rpm_meter_unit.sv
tb/sv/testbench.sv
